// File: rtl/desc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_pkg - shared types and constants for the debounced edge step counter
// Field widths, item op codes, CSR indexes and the struct that is handed from
// the filter/counter stage to the position stage.
// ----------------------------------------------------------------------------
package desc_pkg;

   localparam int CNT_W  = 16;  // edge counter
   localparam int POS_W  = 12;  // reported position
   localparam int INIT_W = 12;  // reload value in turns
   localparam int THR_W  = 4;   // hysteresis thresholds

   localparam logic [THR_W-1:0] LOW_THR_RESET  = 4'd2;
   localparam logic [THR_W-1:0] HIGH_THR_RESET = 4'd6;

   typedef enum logic [0:0] {
      OP_TICK   = 1'b0,
      OP_RELOAD = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_LOW_THR  = 1'b0,
      REG_HIGH_THR = 1'b1
   } csr_index_type;

   // State after one item, waiting for the position divide
   typedef struct packed {
      logic [CNT_W-1:0] counter;
      logic             changed;
      logic             level;
   } stage_type;

endpackage

// File: rtl/desc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_core - sample filter, hysteresis comparator and edge counter
// Updates the filter state and the counter for each accepted transaction and
// registers the counter, changed flag and level for the position stage.
// ----------------------------------------------------------------------------
module desc_core #(
   parameter int WINDOW          = 8,
   parameter int COUNTS_PER_TURN = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 op,
   input  logic                                 pin_level,
   input  logic signed [desc_pkg::INIT_W-1:0]   init_value,
   input  logic [desc_pkg::THR_W-1:0]           low_thr,
   input  logic [desc_pkg::THR_W-1:0]           high_thr,
   output desc_pkg::stage_type                  stage_q
);
   import desc_pkg::*;

   localparam int ONES_W = $clog2(WINDOW + 1);
   localparam int CMP_W  = (ONES_W > THR_W) ? ONES_W : THR_W;
   localparam logic [CNT_W-1:0] CPT_K = CNT_W'(COUNTS_PER_TURN);

   logic [WINDOW-1:0]  history_ff, history_in;
   logic [ONES_W-1:0]  ones_ff, ones_in, ones_tick;
   logic               level_ff, level_in;
   logic [CNT_W-1:0]   counter_ff, counter_in;
   logic               changed;
   logic [CNT_W-1:0]   init_ext;
   logic [2*CNT_W-1:0] reload_prod;
   stage_type          stage_ff;

   assign init_ext    = {{(CNT_W-INIT_W){init_value[INIT_W-1]}}, init_value};
   assign reload_prod = init_ext * CPT_K;   // only the low half is kept (wraps)

   // oldest sample leaves, newest enters
   assign ones_tick = ones_ff - ONES_W'(history_ff[WINDOW-1]) + ONES_W'(pin_level);

   always_comb begin
      history_in = history_ff;
      ones_in    = ones_ff;
      level_in   = level_ff;
      counter_in = counter_ff;
      changed    = 1'b0;
      if (accept) begin
         if (op == OP_RELOAD) begin
            history_in = '0;
            ones_in    = '0;
            level_in   = 1'b0;
            counter_in = reload_prod[CNT_W-1:0];
            changed    = 1'b1;
         end else begin
            history_in = {history_ff[WINDOW-2:0], pin_level};
            ones_in    = ones_tick;
            if (!level_ff) begin
               if (CMP_W'(ones_tick) > CMP_W'(high_thr)) begin
                  level_in   = 1'b1;
                  counter_in = counter_ff - CNT_W'(1);
                  changed    = 1'b1;
               end
            end else if (CMP_W'(ones_tick) < CMP_W'(low_thr)) begin
               level_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         ones_ff    <= '0;
         level_ff   <= 1'b0;
         counter_ff <= '0;
      end else begin
         history_ff <= history_in;
         ones_ff    <= ones_in;
         level_ff   <= level_in;
         counter_ff <= counter_in;
      end
   end

   // payload only, qualified by the valid bit kept at the top level
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.counter <= counter_in;
         stage_ff.changed <= changed;
         stage_ff.level   <= level_in;
      end
   end

   assign stage_q = stage_ff;

endmodule

// File: rtl/desc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_div - position stage
// Divides the signed counter by counts-per-turn (truncating toward zero) with
// a constant reciprocal multiply, and holds the response register.
// ----------------------------------------------------------------------------
module desc_div #(
   parameter int COUNTS_PER_TURN = 16
) (
   input  logic                                clock,
   input  logic                                load,
   input  desc_pkg::stage_type                 stage_d,
   output logic signed [desc_pkg::POS_W-1:0]   rsp_position,
   output logic                                rsp_changed,
   output logic                                rsp_filtered_level
);
   import desc_pkg::*;

   // exact for magnitudes below 2**CNT_W: ceil(2**(CNT_W+l) / d), l = ceil(log2 d)
   localparam int SH = CNT_W + $clog2(COUNTS_PER_TURN);
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + longint'(COUNTS_PER_TURN) - 64'd1) / longint'(COUNTS_PER_TURN);
   localparam int RECIP_W = CNT_W + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic                       neg;
   logic [CNT_W-1:0]           mag;
   logic [CNT_W+RECIP_W-1:0]   prod;
   logic [CNT_W-1:0]           quot, quot_sgn;
   logic [POS_W-1:0]           position_ff;
   logic                       changed_ff, level_ff;

   assign neg      = stage_d.counter[CNT_W-1];
   assign mag      = neg ? (CNT_W'(0) - stage_d.counter) : stage_d.counter;
   assign prod     = mag * RECIP;
   assign quot     = CNT_W'(prod >> SH);
   assign quot_sgn = neg ? (CNT_W'(0) - quot) : quot;

   always_ff @(posedge clock) begin
      if (load) begin
         position_ff <= quot_sgn[POS_W-1:0];   // wraps when out of range
         changed_ff  <= stage_d.changed;
         level_ff    <= stage_d.level;
      end
   end

   assign rsp_position       = position_ff;
   assign rsp_changed        = changed_ff;
   assign rsp_filtered_level = level_ff;

endmodule

// File: rtl/debounced_edge_step_counter.sv
`timescale 1ns / 1ps
// Flow: an accepted transaction is held in the stage 1 register, then in the
//   response register, where it is on rsp_*.
// Throughput: one transaction per cycle when req_stall is low; two register
//   stages (filter/counter update, reciprocal-multiply divide), bubble fill.
// Reset: synchronous, active high; clears filter, level, counter, valid bits,
//   and sets thresholds to low = 2, high = 6. No clearing pass.
// ----------------------------------------------------------------------------
// debounced_edge_step_counter - moving-window debounce with hysteresis
// Counts qualified rising edges of a sampled pin downward in a 16-bit
// wrapping counter and reports the position in turns on every transaction.
// ----------------------------------------------------------------------------
module debounced_edge_step_counter #(
   parameter int WINDOW          = 8,
   parameter int COUNTS_PER_TURN = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic                                req_pin_level,
   input  logic signed [desc_pkg::INIT_W-1:0]  req_init_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [desc_pkg::POS_W-1:0]   rsp_position,
   output logic                                rsp_changed,
   output logic                                rsp_filtered_level,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [desc_pkg::THR_W-1:0]          csr_wdata
);
   import desc_pkg::*;

   logic [THR_W-1:0] low_thr_ff, low_thr_in;
   logic [THR_W-1:0] high_thr_ff, high_thr_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_en;     // response register may load
   logic             s1_en;      // stage 1 register may load
   logic             req_accept;
   stage_type        stage_q;

   // ------------------------------------------------------------------
   // Pipeline control. Each stage loads when it is empty or the stage
   // after it moves, so bubbles close up and a held response only stalls
   // the request side once both stages are full.
   // ------------------------------------------------------------------
   assign out_en     = !rsp_valid_ff || !rsp_stall;
   assign s1_en      = !s1_valid_ff || out_en;
   assign req_stall  = !s1_en;
   assign req_accept = req_valid && s1_en;

   assign s1_valid_in  = s1_en ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Threshold registers. Writes are always taken; software must write them
   // only while no transaction is in flight, as the block does not enforce it.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      low_thr_in  = low_thr_ff;
      high_thr_in = high_thr_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_LOW_THR:  low_thr_in  = csr_wdata;
            REG_HIGH_THR: high_thr_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= LOW_THR_RESET;
         high_thr_ff <= HIGH_THR_RESET;
      end else begin
         low_thr_ff  <= low_thr_in;
         high_thr_ff <= high_thr_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: window shift, ones count, hysteresis and edge counter.
   // The state moves on the accepting edge, so the next transaction sees
   // the updated state.
   // ------------------------------------------------------------------
   desc_core #(
      .WINDOW          (WINDOW),
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .op         (req_op),
      .pin_level  (req_pin_level),
      .init_value (req_init_value),
      .low_thr    (low_thr_ff),
      .high_thr   (high_thr_ff),
      .stage_q    (stage_q)
   );

   // ------------------------------------------------------------------
   // Stage 2: counter / counts-per-turn into the response register.
   // ------------------------------------------------------------------
   desc_div #(
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_div (
      .clock              (clock),
      .load               (out_en && s1_valid_ff),
      .stage_d            (stage_q),
      .rsp_position       (rsp_position),
      .rsp_changed        (rsp_changed),
      .rsp_filtered_level (rsp_filtered_level)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a reload always reports a change with the level cleared
   a_reload_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_RELOAD)
      |=> s1_valid_ff && stage_q.changed && !stage_q.level)
      else $error("reload did not flag change / clear level");

   // a full stage 1 that cannot drain keeps its transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_en |=> s1_valid_ff && $stable(stage_q))
      else $error("stage 1 transaction lost while stalled");

   // a counter step on a tick only happens together with a high level
   a_tick_change: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_TICK) |=> stage_q.changed == 1'b0 || stage_q.level)
      else $error("counter stepped without a rising level");

   // no transaction enters while the pipe is full and the output is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("request accepted into a full pipeline");

endmodule
